[design/rimtf_pkg.sv]
`default_nettype none
package rimtf_pkg;

  localparam int unsigned CFG_W = 5;

  // operation codes; code three behaves as a read
  localparam logic [1:0] OP_TOUCH  = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // result status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_MOVED     = 3'd1;
  localparam logic [2:0] ST_FIRST     = 3'd2;
  localparam logic [2:0] ST_REMOVED   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_DISABLED  = 3'd5;
  localparam logic [2:0] ST_ENTRY     = 3'd6;
  localparam logic [2:0] ST_EMPTY     = 3'd7;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] entry_index;
    logic [31:0] entry_stamp;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_index;
    logic [31:0] out_stamp;
    logic [4:0]  list_count;
    logic        last;
  } rsp_t;

  // per-cell update command, highest priority first
  typedef struct packed {
    logic load_new;    // take the incoming pair
    logic clear;       // index to zero, stamp from the removed slot
    logic take_left;   // take the neighbour nearer the front
    logic take_right;  // take the neighbour nearer the tail (wraps)
  } cell_ctrl_t;

endpackage
`default_nettype wire

[design/rimtf_cell.sv]
`default_nettype none
module rimtf_cell #(
  parameter int unsigned IW  = 32,
  parameter int unsigned STW = 32
) (
  input  wire                     clk,
  input  rimtf_pkg::cell_ctrl_t   ctrl,
  input  wire  [IW-1:0]           new_idx,
  input  wire  [STW-1:0]          new_stamp,
  input  wire  [STW-1:0]          keep_stamp,
  input  wire  [IW-1:0]           left_idx,
  input  wire  [STW-1:0]          left_stamp,
  input  wire  [IW-1:0]           right_idx,
  input  wire  [STW-1:0]          right_stamp,
  output logic [IW-1:0]           idx,
  output logic [STW-1:0]          stamp,
  output logic                    hit
);
  import rimtf_pkg::*;

  assign hit = (idx == new_idx);

  always_ff @(posedge clk) begin
    if (ctrl.load_new) begin
      idx   <= new_idx;
      stamp <= new_stamp;
    end else if (ctrl.clear) begin
      idx   <= '0;
      stamp <= keep_stamp;
    end else if (ctrl.take_left) begin
      idx   <= left_idx;
      stamp <= left_stamp;
    end else if (ctrl.take_right) begin
      idx   <= right_idx;
      stamp <= right_stamp;
    end
  end

endmodule
`default_nettype wire

[design/recent_index_move_to_front_list_unit.sv]
`default_nettype none
// Move-to-front recency list of (index, stamp) pairs, held in a row of
// MAX_ENTRIES cells, front at cell 0. A command transfers when start is high
// and busy is low; busy stays high until the command's last result is out.
// Results appear one per cycle on result with strobe high for one cycle; the
// receiver cannot stall them, so it must take every strobed cycle.
// Touch and remove put out their single result after latching the command,
// comparing in every cell, shifting the row and counting live entries; with
// a capacity of zero they skip the compare and shift steps. A read skips the
// compare and shift, counts live entries, then rotates the whole row once
// round, one cell per cycle, strobing one result per live entry as the
// entries reach the front. A read of an empty list gives its one "empty"
// result from the count step and does not rotate. The row rotation sets the
// read time; the touch/remove time is set by the compare and shift steps.
// max_count is written through cfg_valid/cfg_ready (always ready) by the user
// only while idle, which the block itself does not enforce; it is sampled
// when a command transfers. Stored slots need no clearing after reset: only
// written slots are ever listed.
module recent_index_move_to_front_list_unit #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned INDEX_BITS  = 32,
  parameter int unsigned STAMP_BITS  = 32
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               start,
  output logic                              busy,
  input  rimtf_pkg::req_t                   req,
  output rimtf_pkg::rsp_t                   result,
  output logic                              strobe,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [rimtf_pkg::CFG_W-1:0]       cfg_data
);
  import rimtf_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);          // counts 0..MAX
  localparam int unsigned PW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_APPLY  = 6'b000100,
    S_COUNT  = 6'b001000,
    S_READ   = 6'b010000,
    S_SPARE  = 6'b100000
  } state_t;

  state_t                 state;
  logic [CFG_W-1:0]       max_count;
  logic [1:0]             op_q;
  logic [INDEX_BITS-1:0]  idx_q;
  logic [STAMP_BITS-1:0]  stamp_q;
  logic [CW-1:0]          cap_q;
  logic [CW-1:0]          count_q;
  logic [CW-1:0]          stored_length;
  logic [CW-1:0]          live_q;
  logic [2:0]             status_q;
  logic [PW-1:0]          step;
  logic [MAX_ENTRIES-1:0] match_q;

  // cell row
  logic [INDEX_BITS-1:0]  cell_idx   [MAX_ENTRIES];
  logic [STAMP_BITS-1:0]  cell_stamp [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] cell_hit;
  cell_ctrl_t             ctrl       [MAX_ENTRIES];

  // combinational helpers
  logic [MAX_ENTRIES-1:0] ahead;      // a match lies strictly in front
  logic [MAX_ENTRIES-1:0] first;      // first match, one-hot
  logic                   found;
  logic [STAMP_BITS-1:0]  keep;
  logic [CW-1:0]          newlen;
  logic [2:0]             apply_status;
  logic [CW-1:0]          live;
  logic [CW-1:0]          cap_c;
  logic [CW-1:0]          count_c;
  logic [63:0]            in_idx_w;
  logic [63:0]            in_stamp_w;
  logic [63:0]            out_idx_w;
  logic [63:0]            out_stamp_w;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // field widths vs. stored widths
  assign in_idx_w    = 64'(req.entry_index);
  assign in_stamp_w  = 64'(req.entry_stamp);
  assign out_idx_w   = 64'(cell_idx[0]);
  assign out_stamp_w = 64'(cell_stamp[0]);

  // capacity clamp to the physical row
  assign cap_c   = (32'(max_count) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(max_count);
  assign count_c = (stored_length < cap_q) ? stored_length : cap_q;

  genvar g;
  generate
    for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      localparam int unsigned LEFT  = (g == 0) ? MAX_ENTRIES - 1 : g - 1;
      localparam int unsigned RIGHT = (g == MAX_ENTRIES - 1) ? 0 : g + 1;
      rimtf_cell #(
        .IW  (INDEX_BITS),
        .STW (STAMP_BITS)
      ) u_cell (
        .clk         (clk),
        .ctrl        (ctrl[g]),
        .new_idx     (idx_q),
        .new_stamp   (stamp_q),
        .keep_stamp  (keep),
        .left_idx    (cell_idx[LEFT]),
        .left_stamp  (cell_stamp[LEFT]),
        .right_idx   (cell_idx[RIGHT]),
        .right_stamp (cell_stamp[RIGHT]),
        .idx         (cell_idx[g]),
        .stamp       (cell_stamp[g]),
        .hit         (cell_hit[g])
      );
    end
  endgenerate

  // first-match decode and row commands
  always_comb begin
    logic seen;
    seen         = 1'b0;
    keep         = '0;
    apply_status = ST_NOT_FOUND;
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      ahead[k] = seen;
      first[k] = match_q[k] & ~seen;
      seen     = seen | match_q[k];
      if (first[k]) keep = keep | cell_stamp[k];
    end
    found  = seen;
    newlen = (count_q < cap_q) ? count_q + CW'(1) : cap_q;

    for (int k = 0; k < MAX_ENTRIES; k++) ctrl[k] = '0;

    if (state == S_APPLY) begin
      if (op_q == OP_TOUCH) begin
        if (found && first[0]) begin
          apply_status = ST_FIRST;
        end else begin
          apply_status     = found ? ST_MOVED : ST_INSERTED;
          ctrl[0].load_new = 1'b1;
          for (int k = 1; k < MAX_ENTRIES; k++) begin
            ctrl[k].take_left = found ? ~ahead[k] : (CW'(k) < newlen);
          end
        end
      end else if (found) begin
        // remove: close the gap, zeroed slot goes to the tail of the window
        apply_status = ST_REMOVED;
        for (int k = 0; k < MAX_ENTRIES; k++) begin
          if (CW'(k) + CW'(1) == count_q) ctrl[k].clear = 1'b1;
          else if ((ahead[k] | first[k]) && (CW'(k) + CW'(1) < count_q))
            ctrl[k].take_right = 1'b1;
        end
      end
    end else if (state == S_READ) begin
      // rotate towards the front; a full turn restores the row
      for (int k = 0; k < MAX_ENTRIES; k++) ctrl[k].take_right = 1'b1;
    end
  end

  // live entries: stored length less trailing zeroed slots
  always_comb begin
    live = '0;
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      if ((cell_idx[k] != '0) && (CW'(k) < stored_length)) live = CW'(k + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      max_count     <= CFG_W'(16);
      stored_length <= '0;
      strobe        <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cfg_valid && cfg_ready) max_count <= cfg_data;

      case (state)
        S_IDLE: begin
          if (start) begin
            op_q    <= (req.operation[1]) ? OP_READ : req.operation;
            idx_q   <= in_idx_w[INDEX_BITS-1:0];
            stamp_q <= in_stamp_w[STAMP_BITS-1:0];
            cap_q   <= cap_c;
            if (req.operation[1]) begin
              state <= S_COUNT;
            end else if (cap_c == '0) begin
              status_q <= ST_DISABLED;
              state    <= S_COUNT;
            end else begin
              state <= S_SEARCH;
            end
          end
        end

        S_SEARCH: begin
          count_q <= count_c;
          for (int k = 0; k < MAX_ENTRIES; k++)
            match_q[k] <= cell_hit[k] && (CW'(k) < count_c);
          state <= S_APPLY;
        end

        S_APPLY: begin
          status_q <= apply_status;
          if (op_q == OP_TOUCH && !found && newlen > stored_length)
            stored_length <= newlen;
          state <= S_COUNT;
        end

        S_COUNT: begin
          live_q            <= live;
          result.out_index  <= '0;
          result.out_stamp  <= '0;
          result.list_count <= 5'(live);
          result.last       <= 1'b1;
          if (op_q == OP_READ) begin
            if (live == '0) begin
              result.status <= ST_EMPTY;
              strobe        <= 1'b1;
              state         <= S_IDLE;
            end else begin
              step  <= '0;
              state <= S_READ;
            end
          end else begin
            result.status <= status_q;
            strobe        <= 1'b1;
            state         <= S_IDLE;
          end
        end

        S_READ: begin
          result.status     <= ST_ENTRY;
          result.out_index  <= out_idx_w[31:0];
          result.out_stamp  <= out_stamp_w[31:0];
          result.list_count <= 5'(live_q);
          result.last       <= (32'(step) + 32'd1 == 32'(live_q));
          strobe            <= (32'(step) < 32'(live_q));
          if (32'(step) == 32'(MAX_ENTRIES - 1)) state <= S_IDLE;
          else step <= step + PW'(1);
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
